// ----- design/dskmp_pkg.sv -----
// Shared constants for the difference-sequence KMP matcher.
`default_nettype none

package dskmp_pkg;

    localparam int MAX_PATTERN_DEF = 256;

    localparam int CFG_W    = 9;
    localparam int HEIGHT_W = 30;
    localparam int DIFF_W   = 31;
    localparam int COUNT_W  = 32;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 40;

    localparam logic OP_PATTERN = 1'b0;
    localparam logic OP_TEXT    = 1'b1;

endpackage

`default_nettype wire

// ----- design/dskmp_ram.sv -----
// Simple dual-port memory with one write port and one registered read port.
`default_nettype none

module dskmp_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 255,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- design/difference_sequence_kmp_matcher_top.sv -----
// Top level of the difference-sequence KMP matcher with its sequencer.
//
//  Channel  Direction  Words                 Contents
//  cfg      in         cfg_data              pattern length, 9 bits
//  s_axis   in         tdata, tuser          height and first mark; operation
//  m_axis   out        tdata                 matched flag and running count
//
// A word that needs no store read passes through the EXEC and DONE states to the
// output register, and the sequencer is then idle for the next word. Each
// comparison step of a walk passes through the RD and CMP states, since every
// step reads both stores through their registered read ports, and a completed
// occurrence adds the LRD and LCMP states for the read of the closing link.
// Reset clears all control state; the stores are written before they are read.
// A new word is taken only while the sequencer is idle, and the result waits in
// a single output register until the sink takes it.
`default_nettype none

module difference_sequence_kmp_matcher_top
    import dskmp_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_W-1:0]      cfg_data,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // Fields from bit 0: height (30), first (1), zero pad (1).
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // Fields from bit 0: operation (1).
    input  wire logic                  s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // Fields from bit 0: matched (1), match_count (32), zero pad (7).
    output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

    localparam int DEPTH  = MAX_PATTERN - 1;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int POS_W  = $clog2(MAX_PATTERN);
    localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
    localparam int EL_W   = (LEN_W > CFG_W) ? LEN_W : CFG_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_LRD  = 3'd4;
    localparam logic [2:0] S_LCMP = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [CFG_W-1:0]    plen_reg, plen_next;
    logic                op_reg, op_next;
    logic [HEIGHT_W-1:0] h_reg, h_next;
    logic                first_reg, first_next;
    logic [HEIGHT_W-1:0] last_ph_reg, last_ph_next;
    logic [HEIGHT_W-1:0] last_th_reg, last_th_next;
    logic [LEN_W-1:0]    loaded_reg, loaded_next;
    logic [POS_W-1:0]    blen_reg, blen_next;
    logic [POS_W-1:0]    mpos_reg, mpos_next;
    logic                started_reg, started_next;
    logic [COUNT_W-1:0]  occ_reg, occ_next;
    logic [DIFF_W-1:0]   d_reg, d_next;
    logic [POS_W-1:0]    j_reg, j_next;
    logic [ADDR_W-1:0]   idx_reg, idx_next;
    logic                hit_reg, hit_next;
    logic                ovalid_reg, ovalid_next;
    logic                omatch_reg, omatch_next;
    logic [COUNT_W-1:0]  ocount_reg, ocount_next;

    logic [EL_W-1:0]     plen_ext;
    logic [EL_W-1:0]     eff_len;
    logic [EL_W-1:0]     dcount;
    logic [EL_W-1:0]     loaded_ext;
    logic [COUNT_W-1:0]  occ_inc;
    logic [DIFF_W-1:0]   pdiff;
    logic [DIFF_W-1:0]   tdiff;
    logic [ADDR_W-1:0]   load_idx;
    logic                diff_eq;
    logic [POS_W-1:0]    j_ext;

    logic                diffs_we;
    logic [ADDR_W-1:0]   diffs_waddr;
    logic [DIFF_W-1:0]   diffs_wdata;
    logic [ADDR_W-1:0]   diffs_raddr;
    logic [DIFF_W-1:0]   diffs_rdata;
    logic                links_we;
    logic [ADDR_W-1:0]   links_waddr;
    logic [POS_W-1:0]    links_wdata;
    logic [ADDR_W-1:0]   links_raddr;
    logic [POS_W-1:0]    links_rdata;

    dskmp_ram #(
        .WIDTH  (DIFF_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_diffs (
        .clk     (clk),
        .wr_en   (diffs_we),
        .wr_addr (diffs_waddr),
        .wr_data (diffs_wdata),
        .rd_addr (diffs_raddr),
        .rd_data (diffs_rdata)
    );

    dskmp_ram #(
        .WIDTH  (POS_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_links (
        .clk     (clk),
        .wr_en   (links_we),
        .wr_addr (links_waddr),
        .wr_data (links_wdata),
        .rd_addr (links_raddr),
        .rd_data (links_rdata)
    );

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - COUNT_W - 1){1'b0}}, ocount_reg, omatch_reg};

    assign plen_ext   = EL_W'(plen_reg);
    assign eff_len    = (plen_reg == '0) ? EL_W'(1) :
                        (plen_ext > EL_W'(MAX_PATTERN)) ? EL_W'(MAX_PATTERN) : plen_ext;
    assign dcount     = eff_len - EL_W'(1);
    assign loaded_ext = EL_W'(loaded_reg);
    assign occ_inc    = (occ_reg == '1) ? occ_reg : occ_reg + COUNT_W'(1);
    assign pdiff      = {1'b0, h_reg} - {1'b0, last_ph_reg};
    assign tdiff      = {1'b0, h_reg} - {1'b0, last_th_reg};
    assign load_idx   = ADDR_W'(loaded_ext - EL_W'(1));
    assign diff_eq    = (diffs_rdata == d_reg);
    assign j_ext      = j_reg + POS_W'(diff_eq);

    assign diffs_raddr = j_reg[ADDR_W-1:0];
    assign links_raddr = (state_reg == S_LRD) ? ADDR_W'(dcount - EL_W'(1))
                                              : ADDR_W'(j_reg - POS_W'(1));

    always_comb
    begin
        state_next   = state_reg;
        plen_next    = plen_reg;
        op_next      = op_reg;
        h_next       = h_reg;
        first_next   = first_reg;
        last_ph_next = last_ph_reg;
        last_th_next = last_th_reg;
        loaded_next  = loaded_reg;
        blen_next    = blen_reg;
        mpos_next    = mpos_reg;
        started_next = started_reg;
        occ_next     = occ_reg;
        d_next       = d_reg;
        j_next       = j_reg;
        idx_next     = idx_reg;
        hit_next     = hit_reg;
        ovalid_next  = ovalid_reg;
        omatch_next  = omatch_reg;
        ocount_next  = ocount_reg;
        diffs_we     = 1'b0;
        diffs_waddr  = load_idx;
        diffs_wdata  = pdiff;
        links_we     = 1'b0;
        links_waddr  = idx_reg;
        links_wdata  = j_ext;

        if (cfg_valid && cfg_ready)
        begin
            plen_next = cfg_data;
        end

        if (ovalid_reg && m_axis_tready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next    = s_axis_tuser;
                    h_next     = s_axis_tdata[HEIGHT_W-1:0];
                    first_next = s_axis_tdata[HEIGHT_W];
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                hit_next   = 1'b0;
                state_next = S_DONE;
                if (op_reg == OP_PATTERN)
                begin
                    mpos_next = '0;
                    if (first_reg || loaded_reg == '0)
                    begin
                        loaded_next  = LEN_W'(1);
                        blen_next    = '0;
                        last_ph_next = h_reg;
                    end
                    else if (loaded_ext < eff_len)
                    begin
                        diffs_we     = 1'b1;
                        loaded_next  = loaded_reg + LEN_W'(1);
                        last_ph_next = h_reg;
                        d_next       = pdiff;
                        idx_next     = load_idx;
                        if (load_idx == '0)
                        begin
                            blen_next   = '0;
                            links_we    = 1'b1;
                            links_waddr = '0;
                            links_wdata = '0;
                        end
                        else
                        begin
                            j_next     = (blen_reg >= POS_W'(load_idx)) ? '0 : blen_reg;
                            state_next = S_RD;
                        end
                    end
                end
                else
                begin
                    if (first_reg || !started_reg)
                    begin
                        started_next = 1'b1;
                        last_th_next = h_reg;
                        mpos_next    = '0;
                        occ_next     = (eff_len == EL_W'(1)) ? COUNT_W'(1) : '0;
                        hit_next     = (eff_len == EL_W'(1));
                    end
                    else if (eff_len == EL_W'(1))
                    begin
                        last_th_next = h_reg;
                        occ_next     = occ_inc;
                        hit_next     = 1'b1;
                    end
                    else
                    begin
                        last_th_next = h_reg;
                        if (loaded_ext < eff_len)
                        begin
                            mpos_next = '0;
                        end
                        else
                        begin
                            d_next     = tdiff;
                            j_next     = (EL_W'(mpos_reg) >= dcount) ? '0 : mpos_reg;
                            state_next = S_RD;
                        end
                    end
                end
            end
            S_RD:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (j_reg != '0 && !diff_eq)
                begin
                    j_next     = links_rdata;
                    state_next = S_RD;
                end
                else if (op_reg == OP_PATTERN)
                begin
                    links_we   = 1'b1;
                    blen_next  = j_ext;
                    state_next = S_DONE;
                end
                else if (EL_W'(j_ext) == dcount)
                begin
                    hit_next   = 1'b1;
                    occ_next   = occ_inc;
                    state_next = S_LRD;
                end
                else
                begin
                    mpos_next  = j_ext;
                    state_next = S_DONE;
                end
            end
            S_LRD:
            begin
                state_next = S_LCMP;
            end
            S_LCMP:
            begin
                mpos_next  = links_rdata;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!ovalid_reg || m_axis_tready)
                begin
                    ovalid_next = 1'b1;
                    omatch_next = hit_reg;
                    ocount_next = occ_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            plen_reg    <= CFG_W'(1);
            last_ph_reg <= '0;
            last_th_reg <= '0;
            loaded_reg  <= '0;
            blen_reg    <= '0;
            mpos_reg    <= '0;
            started_reg <= 1'b0;
            occ_reg     <= '0;
            hit_reg     <= 1'b0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            plen_reg    <= plen_next;
            last_ph_reg <= last_ph_next;
            last_th_reg <= last_th_next;
            loaded_reg  <= loaded_next;
            blen_reg    <= blen_next;
            mpos_reg    <= mpos_next;
            started_reg <= started_next;
            occ_reg     <= occ_next;
            hit_reg     <= hit_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        h_reg      <= h_next;
        first_reg  <= first_next;
        d_reg      <= d_next;
        j_reg      <= j_next;
        idx_reg    <= idx_next;
        omatch_reg <= omatch_next;
        ocount_reg <= ocount_next;
    end

    a_accept_starts_exec: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> state_reg == S_EXEC)
        else $error("Accepted word did not start execution.");

    a_hit_only_text: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE && hit_reg |-> op_reg == OP_TEXT)
        else $error("Match reported for a pattern word.");

    a_build_walk_below_index: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CMP && op_reg == OP_PATTERN |-> j_reg < POS_W'(idx_reg))
        else $error("Failure-link walk reached the entry being built.");

    a_count_steps: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg != $past(occ_reg) |->
            (occ_reg == $past(occ_reg) + COUNT_W'(1)) || (occ_reg <= COUNT_W'(1)))
        else $error("Occurrence count moved by more than one.");

endmodule

`default_nettype wire
